// ===== rtl/fsc_pkg.sv =====
// Shared types, widths and plane tables for the frustum sphere cull core.
// Used by every module under rtl/; depends on nothing else.
`default_nettype none

package fsc_pkg;

  // Field widths
  localparam int DataW     = 32;
  localparam int RadW      = 31;
  localparam int ColCount  = 4;
  localparam int RowCount  = 4;
  localparam int ColIdxW   = 2;

  // Arithmetic widths: 32x32 product, pair sum, column dot, plane distance
  localparam int ProdW     = 2 * DataW;
  localparam int WShiftW   = DataW + 16;
  localparam int PairW     = ProdW + 1;
  localparam int DotW      = PairW + 1;
  localparam int DistW     = DotW + 2;

  // Planes
  localparam int PlaneCount = 6;
  localparam int PlaneIdxW  = 3;
  localparam logic [PlaneIdxW-1:0] NoPlane = 3'd6;

  // Item kinds
  localparam logic ModeLoad = 1'b0;
  localparam logic ModeTest = 1'b1;

  // Plane i is d4 + d(PlaneCol[i]) or d4 - d(PlaneCol[i]) when PlaneNeg[i] is set
  localparam logic [ColIdxW-1:0] PlaneCol [PlaneCount] =
    '{2'd2, 2'd2, 2'd0, 2'd0, 2'd1, 2'd1};
  localparam logic [PlaneCount-1:0] PlaneNeg = 6'b011010;

  typedef logic [DataW-1:0] entry_t;
  typedef logic [RadW-1:0]  radius_t;

  // Load enables for the pipeline registers behind the input stage
  typedef struct packed {
    logic prod;
    logic pair;
    logic dot;
    logic res;
  } stage_en_t;

endpackage

`default_nettype wire

// ===== rtl/fsc_matrix_store.sv =====
// Column store of the view-projection matrix: four columns of four entries.
// Depends on fsc_pkg. Entries hold no reset value; a load beat writes one column.
`default_nettype none

module fsc_matrix_store (
  input  wire logic                          clk_i,
  input  wire logic                          wr_en_i,
  input  wire logic [fsc_pkg::ColIdxW-1:0]   wr_col_i,
  input  wire fsc_pkg::entry_t               wr_entry_i [fsc_pkg::RowCount],
  output fsc_pkg::entry_t                    col_o [fsc_pkg::ColCount][fsc_pkg::RowCount]
);

  fsc_pkg::entry_t mat_q [fsc_pkg::ColCount][fsc_pkg::RowCount];

  // Write the addressed column on a load beat
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      for (int r = 0; r < fsc_pkg::RowCount; r++) begin
        mat_q[wr_col_i][r] <= wr_entry_i[r];
      end
    end
  end

  assign col_o = mat_q;

endmodule

`default_nettype wire

// ===== rtl/fsc_dot_unit.sv =====
// Three-stage dot product pipeline: products, pair sums, column dots.
// Depends on fsc_pkg. Forms d_c = m1*x + m2*y + m3*z + m4*2^16 exactly.
`default_nettype none

module fsc_dot_unit (
  input  wire logic                          clk_i,
  input  wire fsc_pkg::stage_en_t            en_i,
  input  wire logic                          mode_i,
  input  wire logic [fsc_pkg::DataW-1:0]     x_i,
  input  wire logic [fsc_pkg::DataW-1:0]     y_i,
  input  wire logic [fsc_pkg::DataW-1:0]     z_i,
  input  wire fsc_pkg::radius_t              rad_i,
  input  wire fsc_pkg::entry_t               col_i [fsc_pkg::ColCount][fsc_pkg::RowCount],
  output logic                               mode_o,
  output fsc_pkg::radius_t                   rad_o,
  output logic signed [fsc_pkg::DotW-1:0]    dot_o [fsc_pkg::ColCount]
);

  logic signed [fsc_pkg::ProdW-1:0]   prod_d [fsc_pkg::ColCount][3];
  logic signed [fsc_pkg::ProdW-1:0]   prod_q [fsc_pkg::ColCount][3];
  logic signed [fsc_pkg::WShiftW-1:0] wsh_q  [fsc_pkg::ColCount];
  logic                               mode_p_q;
  fsc_pkg::radius_t                   rad_p_q;

  logic signed [fsc_pkg::PairW-1:0]   pair_a_d [fsc_pkg::ColCount];
  logic signed [fsc_pkg::PairW-1:0]   pair_b_d [fsc_pkg::ColCount];
  logic signed [fsc_pkg::PairW-1:0]   pair_a_q [fsc_pkg::ColCount];
  logic signed [fsc_pkg::PairW-1:0]   pair_b_q [fsc_pkg::ColCount];
  logic                               mode_s_q;
  fsc_pkg::radius_t                   rad_s_q;

  logic signed [fsc_pkg::DotW-1:0]    dot_d [fsc_pkg::ColCount];
  logic signed [fsc_pkg::DotW-1:0]    dot_q [fsc_pkg::ColCount];
  logic                               mode_d_q;
  fsc_pkg::radius_t                   rad_d_q;

  // Multiply each column entry by its coordinate
  always_comb begin
    for (int c = 0; c < fsc_pkg::ColCount; c++) begin
      prod_d[c][0] = $signed(col_i[c][0]) * $signed(x_i);
      prod_d[c][1] = $signed(col_i[c][1]) * $signed(y_i);
      prod_d[c][2] = $signed(col_i[c][2]) * $signed(z_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.prod) begin
      prod_q   <= prod_d;
      mode_p_q <= mode_i;
      rad_p_q  <= rad_i;
      for (int c = 0; c < fsc_pkg::ColCount; c++) begin
        wsh_q[c] <= {col_i[c][3], 16'h0000};
      end
    end
  end

  // Add products in pairs, w term scaled by one in Q16.16
  always_comb begin
    for (int c = 0; c < fsc_pkg::ColCount; c++) begin
      pair_a_d[c] = {prod_q[c][0][fsc_pkg::ProdW-1], prod_q[c][0]}
                  + {prod_q[c][1][fsc_pkg::ProdW-1], prod_q[c][1]};
      pair_b_d[c] = {prod_q[c][2][fsc_pkg::ProdW-1], prod_q[c][2]}
                  + {{(fsc_pkg::PairW - fsc_pkg::WShiftW){wsh_q[c][fsc_pkg::WShiftW-1]}},
                     wsh_q[c]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.pair) begin
      pair_a_q <= pair_a_d;
      pair_b_q <= pair_b_d;
      mode_s_q <= mode_p_q;
      rad_s_q  <= rad_p_q;
    end
  end

  // Finish each column dot product
  always_comb begin
    for (int c = 0; c < fsc_pkg::ColCount; c++) begin
      dot_d[c] = {pair_a_q[c][fsc_pkg::PairW-1], pair_a_q[c]}
               + {pair_b_q[c][fsc_pkg::PairW-1], pair_b_q[c]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.dot) begin
      dot_q    <= dot_d;
      mode_d_q <= mode_s_q;
      rad_d_q  <= rad_s_q;
    end
  end

  assign mode_o = mode_d_q;
  assign rad_o  = rad_d_q;
  assign dot_o  = dot_q;

endmodule

`default_nettype wire

// ===== rtl/fsc_plane_test.sv =====
// Plane distance compare and first-failure encode, with the result register.
// Depends on fsc_pkg. Culls when d4 +/- dc + radius is negative.
`default_nettype none

module fsc_plane_test (
  input  wire logic                            clk_i,
  input  wire logic                            en_i,
  input  wire logic                            mode_i,
  input  wire fsc_pkg::radius_t                rad_i,
  input  wire logic signed [fsc_pkg::DotW-1:0] dot_i [fsc_pkg::ColCount],
  output logic                                 visible_o,
  output logic [fsc_pkg::PlaneIdxW-1:0]        failing_plane_o
);

  logic signed [fsc_pkg::DistW-1:0]  w_ext;
  logic signed [fsc_pkg::DistW-1:0]  c_ext;
  logic signed [fsc_pkg::DistW-1:0]  rad_ext;
  logic signed [fsc_pkg::DistW-1:0]  plane_dist;
  logic [fsc_pkg::PlaneCount-1:0]    fail;
  logic [fsc_pkg::PlaneIdxW-1:0]     first_idx;
  logic                              visible_d;
  logic [fsc_pkg::PlaneIdxW-1:0]     plane_d;
  logic                              visible_q;
  logic [fsc_pkg::PlaneIdxW-1:0]     plane_q;

  // Sign of each plane distance plus radius
  always_comb begin
    w_ext      = {{(fsc_pkg::DistW - fsc_pkg::DotW){dot_i[3][fsc_pkg::DotW-1]}}, dot_i[3]};
    rad_ext    = {{(fsc_pkg::DistW - fsc_pkg::RadW - 16){1'b0}}, rad_i, 16'h0000};
    c_ext      = '0;
    plane_dist = '0;
    for (int i = 0; i < fsc_pkg::PlaneCount; i++) begin
      c_ext = {{(fsc_pkg::DistW - fsc_pkg::DotW){dot_i[fsc_pkg::PlaneCol[i]][fsc_pkg::DotW-1]}},
               dot_i[fsc_pkg::PlaneCol[i]]};
      if (fsc_pkg::PlaneNeg[i]) begin
        plane_dist = w_ext - c_ext + rad_ext;
      end else begin
        plane_dist = w_ext + c_ext + rad_ext;
      end
      fail[i] = plane_dist[fsc_pkg::DistW-1];
    end
  end

  // Pick the first failing plane in table order
  always_comb begin
    first_idx = fsc_pkg::NoPlane;
    for (int i = fsc_pkg::PlaneCount - 1; i >= 0; i--) begin
      if (fail[i]) begin
        first_idx = fsc_pkg::PlaneIdxW'(i);
      end
    end
  end

  // Load beats answer not visible and no plane
  always_comb begin
    if (mode_i == fsc_pkg::ModeTest) begin
      visible_d = (fail == '0);
      plane_d   = first_idx;
    end else begin
      visible_d = 1'b0;
      plane_d   = fsc_pkg::NoPlane;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      visible_q <= visible_d;
      plane_q   <= plane_d;
    end
  end

  assign visible_o       = visible_q;
  assign failing_plane_o = plane_q;

endmodule

`default_nettype wire

// ===== rtl/frustum_sphere_cull_core.sv =====
// Frustum sphere cull core: a five-register pipeline that accepts one beat per cycle
// while stall_o is low and returns one result beat per input beat, in order; the
// result shows on valid_o from the result register and is taken at an edge where the
// output is not stalled. The stages are the input register, the 32x32 signed
// multipliers (twelve in parallel), the pair adders, the column dot adders, and the
// plane compare with the result register. A stall on the output backs up stage by
// stage, so empty stages still fill while a result waits. A load beat (mode 0) writes
// one matrix column at acceptance and answers visible 0, failing plane 6; all four
// columns must be loaded before the first test beat. A test beat (mode 1) checks a
// sphere of the given radius, or a point at radius 0, against the six planes.
`default_nettype none

module frustum_sphere_cull_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              valid_i,
  output logic                                   stall_o,
  input  wire logic                              mode_i,
  input  wire logic [fsc_pkg::ColIdxW-1:0]       column_index_i,
  input  wire logic signed [fsc_pkg::DataW-1:0]  entry_row1_i,
  input  wire logic signed [fsc_pkg::DataW-1:0]  entry_row2_i,
  input  wire logic signed [fsc_pkg::DataW-1:0]  entry_row3_i,
  input  wire logic signed [fsc_pkg::DataW-1:0]  entry_row4_i,
  input  wire logic signed [fsc_pkg::DataW-1:0]  point_x_i,
  input  wire logic signed [fsc_pkg::DataW-1:0]  point_y_i,
  input  wire logic signed [fsc_pkg::DataW-1:0]  point_z_i,
  input  wire logic [fsc_pkg::RadW-1:0]          radius_i,
  output logic                                   valid_o,
  input  wire logic                              stall_i,
  output logic                                   visible_o,
  output logic [fsc_pkg::PlaneIdxW-1:0]          failing_plane_o
);

  logic                  v_in_q, v_prod_q, v_pair_q, v_dot_q, v_res_q;
  logic                  ld_in;
  fsc_pkg::stage_en_t    en;
  logic                  accept;
  logic                  mat_we;
  fsc_pkg::entry_t       wr_entry [fsc_pkg::RowCount];
  fsc_pkg::entry_t       cols [fsc_pkg::ColCount][fsc_pkg::RowCount];

  logic                  mode_q;
  logic [fsc_pkg::DataW-1:0] x_q, y_q, z_q;
  fsc_pkg::radius_t      rad_q;

  logic                  mode_dot;
  fsc_pkg::radius_t      rad_dot;
  logic signed [fsc_pkg::DotW-1:0] dot [fsc_pkg::ColCount];

  // Each stage loads when it is empty or its content moves on
  always_comb begin
    en.res  = !v_res_q  || !stall_i;
    en.dot  = !v_dot_q  || en.res;
    en.pair = !v_pair_q || en.dot;
    en.prod = !v_prod_q || en.pair;
    ld_in   = !v_in_q   || en.prod;
  end

  assign stall_o = !ld_in;
  assign accept  = valid_i && ld_in;
  assign mat_we  = accept && (mode_i == fsc_pkg::ModeLoad);

  // Advance valid bits with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_in_q   <= 1'b0;
      v_prod_q <= 1'b0;
      v_pair_q <= 1'b0;
      v_dot_q  <= 1'b0;
      v_res_q  <= 1'b0;
    end else begin
      if (ld_in)   v_in_q   <= valid_i;
      if (en.prod) v_prod_q <= v_in_q;
      if (en.pair) v_pair_q <= v_prod_q;
      if (en.dot)  v_dot_q  <= v_pair_q;
      if (en.res)  v_res_q  <= v_dot_q;
    end
  end

  // Input register for test operands
  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      mode_q <= mode_i;
      x_q    <= point_x_i;
      y_q    <= point_y_i;
      z_q    <= point_z_i;
      rad_q  <= radius_i;
    end
  end

  assign wr_entry[0] = entry_row1_i;
  assign wr_entry[1] = entry_row2_i;
  assign wr_entry[2] = entry_row3_i;
  assign wr_entry[3] = entry_row4_i;

  fsc_matrix_store u_store (
    .clk_i      (clk_i),
    .wr_en_i    (mat_we),
    .wr_col_i   (column_index_i),
    .wr_entry_i (wr_entry),
    .col_o      (cols)
  );

  fsc_dot_unit u_dot (
    .clk_i  (clk_i),
    .en_i   (en),
    .mode_i (mode_q),
    .x_i    (x_q),
    .y_i    (y_q),
    .z_i    (z_q),
    .rad_i  (rad_q),
    .col_i  (cols),
    .mode_o (mode_dot),
    .rad_o  (rad_dot),
    .dot_o  (dot)
  );

  fsc_plane_test u_plane (
    .clk_i           (clk_i),
    .en_i            (en.res),
    .mode_i          (mode_dot),
    .rad_i           (rad_dot),
    .dot_i           (dot),
    .visible_o       (visible_o),
    .failing_plane_o (failing_plane_o)
  );

  assign valid_o = v_res_q;

`ifndef SYNTH
  // A visible result never names a failing plane
  a_visible_no_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && visible_o |-> failing_plane_o == fsc_pkg::NoPlane)
    else $error("visible result carries a failing plane");

  // The plane index never goes past the last plane code
  a_plane_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> failing_plane_o <= fsc_pkg::NoPlane)
    else $error("failing plane index out of range");

  // An empty input stage never pushes back
  a_no_false_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !v_in_q |-> !stall_o)
    else $error("stall raised with the input stage empty");

  // A held result keeps the beat behind it in place
  a_dot_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_dot_q && valid_o && stall_i |=> v_dot_q)
    else $error("pipeline beat lost under output stall");
`endif

endmodule

`default_nettype wire

// ===== tb/frustum_sphere_cull_core_test.sv =====
// Testbench for frustum_sphere_cull_core: matrix column loads and sphere/point cull tests.
// Predicts each verdict with exact wide arithmetic and checks results in order.
// Depends on rtl/fsc_pkg.sv and rtl/frustum_sphere_cull_core.sv, and through the core on the other rtl/ files.
`timescale 1ns / 1ps

module frustum_sphere_cull_core_test;

  typedef logic [fsc_pkg::DataW-1:0]     entry_t;
  typedef logic [fsc_pkg::RadW-1:0]      radius_t;
  typedef logic [fsc_pkg::PlaneIdxW-1:0] plane_t;

  typedef struct packed {
    logic   visible;
    plane_t plane;
  } verdict_t;

  localparam entry_t  QOne    = 32'h0001_0000;
  localparam entry_t  QMin    = 32'h8000_0000;
  localparam entry_t  QMax    = 32'h7FFF_FFFF;
  localparam radius_t RadMax  = 31'h7FFF_FFFF;
  localparam radius_t RadOne  = 31'h0001_0000;

  // Plane i compares w-column plus or minus one other column (0-based)
  localparam int PlaneColumn   [6] = '{2, 2, 0, 0, 1, 1};
  localparam bit PlaneSubtract [6] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 valid_i;
  logic                 stall_o;
  logic                 mode_i;
  logic [1:0]           column_index_i;
  logic signed [31:0]   entry_row1_i, entry_row2_i, entry_row3_i, entry_row4_i;
  logic signed [31:0]   point_x_i, point_y_i, point_z_i;
  radius_t              radius_i;
  logic                 valid_o;
  logic                 stall_i;
  logic                 visible_o;
  plane_t               failing_plane_o;

  // Predictor state: matrix entries by [column][row]
  logic signed [31:0] frustum_mat [4][4];
  verdict_t           verdict_q [$];

  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request = 0;

  frustum_sphere_cull_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .valid_i         (valid_i),
    .stall_o         (stall_o),
    .mode_i          (mode_i),
    .column_index_i  (column_index_i),
    .entry_row1_i    (entry_row1_i),
    .entry_row2_i    (entry_row2_i),
    .entry_row3_i    (entry_row3_i),
    .entry_row4_i    (entry_row4_i),
    .point_x_i       (point_x_i),
    .point_y_i       (point_y_i),
    .point_z_i       (point_z_i),
    .radius_i        (radius_i),
    .valid_o         (valid_o),
    .stall_i         (stall_i),
    .visible_o       (visible_o),
    .failing_plane_o (failing_plane_o)
  );

  // 12 ns clock
  always begin
    #6;
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
  end

  // Exact plane test: first plane whose distance plus radius is negative
  function automatic plane_t first_failing_plane(entry_t x, entry_t y, entry_t z, radius_t r);
    logic signed [95:0] dot [4];
    logic signed [95:0] xs, ys, zs, rad_w, term, plane_dist;
    xs = $signed(x);
    ys = $signed(y);
    zs = $signed(z);
    rad_w = {49'd0, r, 16'd0};
    for (int c = 0; c < 4; c++) begin
      dot[c] = frustum_mat[c][0] * xs + frustum_mat[c][1] * ys + frustum_mat[c][2] * zs
             + frustum_mat[c][3] * 96'sd65536;
    end
    for (int i = 0; i < 6; i++) begin
      term = PlaneSubtract[i] ? -dot[PlaneColumn[i]] : dot[PlaneColumn[i]];
      plane_dist = dot[3] + term + rad_w;
      if (plane_dist < 0) return plane_t'(i);
    end
    return fsc_pkg::NoPlane;
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(int pct);
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Coordinates and matrix entries: mostly near unity so every plane gets hit
  function automatic entry_t pick_value(int span);
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return $urandom;
    if (sel < 16) begin
      case ($urandom_range(4))
        0: return QMin;
        1: return QMax;
        2: return '0;
        3: return '1;
        default: return QOne;
      endcase
    end
    return entry_t'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic radius_t pick_radius();
    int sel;
    sel = $urandom_range(99);
    if (sel < 30) return '0;
    if (sel < 38) return radius_t'($urandom);
    if (sel < 40) return RadMax;
    return radius_t'($urandom_range(0, 2 * 65536));
  endfunction

  // Drive one beat, wait for acceptance, record its expected verdict
  task automatic send_beat(logic mode, logic [1:0] col, entry_t r1, entry_t r2, entry_t r3,
                           entry_t r4, entry_t px, entry_t py, entry_t pz, radius_t rad);
    int gap;
    plane_t plane;
    gap = pick_gap(send_idle_pct);
    @(negedge clk_i);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i        <= 1'b1;
    mode_i         <= mode;
    column_index_i <= col;
    entry_row1_i   <= r1;
    entry_row2_i   <= r2;
    entry_row3_i   <= r3;
    entry_row4_i   <= r4;
    point_x_i      <= px;
    point_y_i      <= py;
    point_z_i      <= pz;
    radius_i       <= rad;
    do @(posedge clk_i); while (stall_o !== 1'b0);
    if (mode == fsc_pkg::ModeLoad) begin
      frustum_mat[col][0] = r1;
      frustum_mat[col][1] = r2;
      frustum_mat[col][2] = r3;
      frustum_mat[col][3] = r4;
      verdict_q.push_back('{visible: 1'b0, plane: fsc_pkg::NoPlane});
    end else begin
      plane = first_failing_plane(px, py, pz, rad);
      verdict_q.push_back('{visible: plane == fsc_pkg::NoPlane, plane: plane});
    end
  endtask

  // Load beat with junk in the ignored test fields
  task automatic load_column(logic [1:0] col, entry_t r1, entry_t r2, entry_t r3, entry_t r4);
    send_beat(fsc_pkg::ModeLoad, col, r1, r2, r3, r4, $urandom, $urandom, $urandom,
              radius_t'($urandom));
  endtask

  // Test beat with junk in the ignored load fields
  task automatic test_sphere(entry_t px, entry_t py, entry_t pz, radius_t rad);
    send_beat(fsc_pkg::ModeTest, 2'($urandom), $urandom, $urandom, $urandom, $urandom,
              px, py, pz, rad);
  endtask

  task automatic load_random_matrix();
    int order [4];
    int k, tmp;
    order = '{0, 1, 2, 3};
    for (int i = 3; i > 0; i--) begin
      k = $urandom_range(i);
      tmp = order[i];
      order[i] = order[k];
      order[k] = tmp;
    end
    foreach (order[i]) begin
      load_column(2'(order[i]), pick_value(131072), pick_value(131072),
                  pick_value(131072), pick_value(131072));
    end
  endtask

  // Identity matrix: unit cube frustum, one point per plane, edge cases
  task automatic test_identity_frustum();
    load_column(2'd0, QOne, '0, '0, '0);
    load_column(2'd1, '0, QOne, '0, '0);
    load_column(2'd2, '0, '0, QOne, '0);
    load_column(2'd3, '0, '0, '0, QOne);
    test_sphere('0, '0, '0, '0);
    test_sphere('0, '0, -2 * QOne, '0);
    test_sphere('0, '0, 2 * QOne, '0);
    test_sphere(-2 * QOne, '0, '0, '0);
    test_sphere(2 * QOne, '0, '0, '0);
    test_sphere('0, 2 * QOne, '0, '0);
    test_sphere('0, -2 * QOne, '0, '0);
    // Touching the plane counts as inside; one LSB less radius culls
    test_sphere(2 * QOne, '0, '0, RadOne);
    test_sphere(2 * QOne, '0, '0, RadOne - 31'd1);
    test_sphere(QOne, '0, '0, '0);
  endtask

  // Full-scale entries and coordinates: products must stay exact
  task automatic test_extreme_values();
    for (int c = 0; c < 4; c++) load_column(2'(c), QMin, QMin, QMin, QMin);
    test_sphere(QMin, QMin, QMin, '0);
    test_sphere(QMax, QMax, QMax, RadMax);
    for (int c = 0; c < 4; c++) load_column(2'(c), QMax, QMax, QMax, QMax);
    test_sphere(QMin, QMax, QMin, RadMax);
  endtask

  // Long output hold while the sender keeps offering beats
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_request = 150;
    for (int n = 0; n < 40; n++) begin
      if (n == 17) load_column(2'd1, pick_value(131072), pick_value(131072),
                               pick_value(131072), pick_value(131072));
      else test_sphere(pick_value(262144), pick_value(262144), pick_value(262144),
                       pick_radius());
    end
  endtask

  // Random stream: matrix reloads among many tests, idle profiles in rotation
  task automatic test_random_stream(int count);
    load_random_matrix();
    for (int n = 0; n < count; n++) begin
      if (n % 100 == 0) begin
        case ((n / 100) % 4)
          0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
          1: begin send_idle_pct = 20; recv_idle_pct = 20; end
          2: begin send_idle_pct = 50; recv_idle_pct = 10; end
          default: begin send_idle_pct = 10; recv_idle_pct = 50; end
        endcase
      end
      if ($urandom_range(199) == 0) load_random_matrix();
      else if ($urandom_range(99) < 6)
        load_column(2'($urandom), pick_value(131072), pick_value(131072),
                    pick_value(131072), pick_value(131072));
      else test_sphere(pick_value(262144), pick_value(262144), pick_value(262144),
                       pick_radius());
    end
  endtask

  // Output side stall: random gaps, plus a long hold on request
  initial begin
    int stall_left;
    int hold_left;
    stall_left = 0;
    hold_left = 0;
    stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_i <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        stall_i <= 1'b1;
      end else begin
        stall_left = pick_gap(recv_idle_pct);
        if (stall_left > 0) begin
          stall_left--;
          stall_i <= 1'b1;
        end else begin
          stall_i <= 1'b0;
        end
      end
    end
  end

  // Check each accepted result beat against the oldest expected verdict
  always @(posedge clk_i) begin
    verdict_t want;
    if (rst_ni && valid_o && !stall_i) begin
      if (verdict_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: visible %0d plane %0d", visible_o,
                   failing_plane_o);
      end else begin
        want = verdict_q.pop_front();
        if (visible_o !== want.visible || failing_plane_o !== want.plane) begin
          mismatches++;
          if (mismatches <= 10)
            $display("verdict mismatch: expected visible %0d plane %0d, got visible %0d plane %0d",
                     want.visible, want.plane, visible_o, failing_plane_o);
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    rst_ni = 1'b0;
    valid_i = 1'b0;
    mode_i = fsc_pkg::ModeLoad;
    column_index_i = '0;
    entry_row1_i = '0;
    entry_row2_i = '0;
    entry_row3_i = '0;
    entry_row4_i = '0;
    point_x_i = '0;
    point_y_i = '0;
    point_z_i = '0;
    radius_i = '0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    test_identity_frustum();
    test_extreme_values();
    test_output_backpressure();
    test_random_stream(1400);

    // Drain the expected verdicts, then watch for stray beats
    @(negedge clk_i);
    valid_i <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
